// ----- hdl/swse_pkg.sv -----
package swse_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int GROW       = $clog2(MAX_WINDOW);

    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 5;
    localparam int WLEN_RESET = 16;

    localparam int IN_W       = TIME_W + VALUE_W;
    localparam int OUT_W      = 48;
    localparam int USER_W     = 2;
    localparam int USER_VALID_BIT  = 0;
    localparam int USER_REUSED_BIT = 1;

    localparam int DS_W     = VALUE_W + 1;
    localparam int PROD_W   = 2 * DS_W;
    localparam int SDT_W    = TIME_W + GROW;
    localparam int SDS_W    = DS_W + GROW;
    localparam int SDTDS_W  = PROD_W - 1 + GROW;
    localparam int SDT2_W   = 2 * TIME_W + GROW;
    localparam int CHUNK_W  = (SDT_W + 1) / 2;
    localparam int PART_W   = SDS_W + CHUNK_W + 1;
    localparam int NUM_W    = 2 * TIME_W + 2 + 2 * GROW;
    localparam int DEN_W    = NUM_W;

    localparam int FRAC_W   = 16;
    localparam int Q_W      = OUT_W + 1;
    localparam int SHIFT_W  = Q_W - FRAC_W;
    localparam int QCNT_W   = $clog2(Q_W);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } div_req_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_W'(MAX_WINDOW - 1) : p - PTR_W'(1);
    endfunction

endpackage

// ----- hdl/swse_ring.sv -----
module swse_ring (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [swse_pkg::PTR_W-1:0]    wr_addr,
    input  swse_pkg::entry_t              wr_data,
    input  logic [swse_pkg::PTR_W-1:0]    rd_addr,
    output swse_pkg::entry_t              rd_data
);
    import swse_pkg::*;

    entry_t mem [MAX_WINDOW];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/swse_div.sv -----
module swse_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  swse_pkg::div_req_t         req,
    output logic                       done,
    output logic [swse_pkg::Q_W-1:0]   quo
);
    import swse_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [Q_W-1:0]    sh_reg, sh_next;
    logic [Q_W-1:0]    q_reg, q_next;

    logic [DEN_W-1:0]  trial;
    logic              ge;

    assign trial = {rem_reg[DEN_W-2:0], sh_reg[Q_W-1]};
    assign ge    = (trial >= den_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DEN_W'(req.mag >> SHIFT_W);
            den_next  = req.den;
            sh_next   = {req.mag[SHIFT_W-1:0], FRAC_W'(0)};
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = ge ? trial - den_reg : trial;
            q_next   = {q_reg[Q_W-2:0], ge};
            sh_next  = {sh_reg[Q_W-2:0], 1'b0};
            cnt_next = cnt_reg + QCNT_W'(1);
            if (cnt_reg == QCNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ----- hdl/sliding_window_slope_estimator_core.sv -----
// channel   dir  handshake                 payload
// cfg       in   cfg_valid / cfg_ready     cfg_data  = window_len
// s_        in   s_tvalid / s_tready       s_tdata   = sample_time, sample_value
// m_        out  m_tvalid / m_tready       m_tdata   = slope; m_tuser = slope_valid, reused
//
// A fit over n entries runs these steps in order: check the newest entry and read the base
// entry, walk the ring with the shared multiplier alternating between dt*dt and dt*ds per
// entry, form the final products in five steps, range-check the quotient, run the bit-serial
// divider, then load the output and reaccept. A repeated timestamp or a fit of fewer than two
// entries goes straight to the output. Reset clears pointer, fill count and cached result; a
// result waiting on m_ blocks only the next result.
module sliding_window_slope_estimator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swse_pkg::CFG_W-1:0]      cfg_data,   // window_len
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swse_pkg::IN_W-1:0]       s_tdata,    // sample_time, sample_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swse_pkg::OUT_W-1:0]      m_tdata,    // slope
    output logic [swse_pkg::USER_W-1:0]     m_tuser     // slope_valid, reused
);
    import swse_pkg::*;

    localparam int NCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NX_W   = CNT_W + 1;
    localparam logic [2:0] FIN_LAST = 3'd4;
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (OUT_W - 1);
    localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_START = 9'b000000100,
        ST_BASE  = 9'b000001000,
        ST_MAC   = 9'b000010000,
        ST_FIN   = 9'b000100000,
        ST_PREP  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CFG_W-1:0]   wlen_reg, wlen_next;
    logic [OUT_W-1:0]   last_slope_reg, last_slope_next;
    logic               last_valid_reg, last_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [TIME_W-1:0]  tin_reg, tin_next;
    logic [VALUE_W-1:0] vin_reg, vin_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic               ph_reg, ph_next;
    logic [TIME_W-1:0]  t0_reg, t0_next;
    logic [VALUE_W-1:0] v0_reg, v0_next;
    logic [TIME_W-1:0]  dt_reg, dt_next;
    logic signed [DS_W-1:0]    ds_reg, ds_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [SDT_W-1:0]          sdt_reg, sdt_next;
    logic signed [SDS_W-1:0]   sds_reg, sds_next;
    logic signed [SDTDS_W-1:0] sdtds_reg, sdtds_next;
    logic [SDT2_W-1:0]         sdt2_reg, sdt2_next;
    logic [2:0]                fcnt_reg, fcnt_next;
    logic signed [PART_W-1:0]  part_reg, part_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [DEN_W-1:0]   den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [OUT_W-1:0]   res_slope_reg, res_slope_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_reused_reg, res_reused_next;
    logic [OUT_W-1:0]   out_slope_reg, out_slope_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_reused_reg, out_reused_next;

    entry_t             rd_data;
    entry_t             wr_data;
    logic               wr_en;
    logic [PTR_W-1:0]   rd_addr;

    logic               hit;
    logic [CNT_W-1:0]   fill_inc;
    logic [NCMP_W-1:0]  wl0, wlc, n_wide;
    logic [CNT_W-1:0]   n_calc;
    logic [NX_W-1:0]    start_sum;
    logic [PTR_W-1:0]   start_calc;
    logic [PTR_W-1:0]   wp_inc;

    logic [TIME_W-1:0]         dt_new;
    logic signed [DS_W-1:0]    ds_new;
    logic signed [DS_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [SDS_W-1:0]   ca;
    logic [CHUNK_W-1:0]        cb;
    logic signed [PART_W-1:0]  part_w;
    logic signed [NUM_W-1:0]   np1;
    logic [DEN_W-1:0]          np2;
    logic [NUM_W-1:0]          mag_w;
    logic [DEN_W-1:0]          rinit;
    logic                      ovf;
    logic [Q_W-1:0]            q_clip;
    logic [OUT_W-1:0]          slope_div;

    div_req_t           div_req;
    logic               div_done;
    logic [Q_W-1:0]     div_quo;

    swse_ring u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_slope_reg;
    assign m_tuser[USER_VALID_BIT]  = out_valid_reg;
    assign m_tuser[USER_REUSED_BIT] = out_reused_reg;

    assign rd_addr = (state_reg == ST_IDLE) ? ptr_dec(wp_reg) : ptr_reg;
    assign wr_data = '{value: vin_reg, stamp: tin_reg};

    assign hit      = (fill_reg != '0) && (rd_data.stamp == tin_reg);
    assign fill_inc = (fill_reg == CNT_W'(MAX_WINDOW)) ? fill_reg : fill_reg + CNT_W'(1);
    assign wp_inc   = ptr_inc(wp_reg);
    assign wl0      = (wlen_reg == '0) ? NCMP_W'(1) : NCMP_W'(wlen_reg);
    assign wlc      = (wl0 > NCMP_W'(MAX_WINDOW)) ? NCMP_W'(MAX_WINDOW) : wl0;
    assign n_wide   = (wlc > NCMP_W'(fill_inc)) ? NCMP_W'(fill_inc) : wlc;
    assign n_calc   = CNT_W'(n_wide);
    assign start_sum = NX_W'(wp_inc) + NX_W'(MAX_WINDOW) - NX_W'(n_calc);
    assign start_calc = (start_sum >= NX_W'(MAX_WINDOW)) ?
                        PTR_W'(start_sum - NX_W'(MAX_WINDOW)) : PTR_W'(start_sum);

    assign dt_new = rd_data.stamp - t0_reg;
    assign ds_new = $signed({rd_data.value[VALUE_W-1], rd_data.value})
                  - $signed({v0_reg[VALUE_W-1], v0_reg});

    assign mul_a  = $signed({1'b0, dt_reg});
    assign mul_b  = ph_reg ? ds_reg : $signed({1'b0, dt_reg});
    assign prod_w = mul_a * mul_b;

    assign ca     = fcnt_reg[1] ? $signed({1'b0, sdt_reg}) : sds_reg;
    assign cb     = fcnt_reg[0] ? CHUNK_W'(sdt_reg >> CHUNK_W) : sdt_reg[CHUNK_W-1:0];
    assign part_w = ca * $signed({1'b0, cb});

    assign np1 = $signed({1'b0, n_reg}) * sdtds_reg;
    assign np2 = n_reg * sdt2_reg;

    assign mag_w = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign rinit = DEN_W'(mag_w >> SHIFT_W);
    assign ovf   = (rinit >= DEN_W'(den_reg));

    always_comb begin
        if (neg_reg) begin
            q_clip    = (div_quo > NEG_LIM) ? NEG_LIM : div_quo;
            slope_div = OUT_W'(Q_W'(0) - q_clip);
        end else begin
            q_clip    = (div_quo > POS_LIM) ? POS_LIM : div_quo;
            slope_div = OUT_W'(q_clip);
        end
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        wlen_next       = wlen_reg;
        last_slope_next = last_slope_reg;
        last_valid_next = last_valid_reg;
        m_tvalid_next   = m_tvalid_reg;
        tin_next        = tin_reg;
        vin_next        = vin_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        ph_next         = ph_reg;
        t0_next         = t0_reg;
        v0_next         = v0_reg;
        dt_next         = dt_reg;
        ds_next         = ds_reg;
        prod_next       = prod_reg;
        sdt_next        = sdt_reg;
        sds_next        = sds_reg;
        sdtds_next      = sdtds_reg;
        sdt2_next       = sdt2_reg;
        fcnt_next       = fcnt_reg;
        part_next       = part_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        res_slope_next  = res_slope_reg;
        res_valid_next  = res_valid_reg;
        res_reused_next = res_reused_reg;
        out_slope_next  = out_slope_reg;
        out_valid_next  = out_valid_reg;
        out_reused_next = out_reused_reg;
        wr_en           = 1'b0;
        div_req.start   = 1'b0;
        div_req.mag     = mag_w;
        div_req.den     = DEN_W'(den_reg);

        if (cfg_valid) begin
            wlen_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tin_next   = s_tdata[TIME_W-1:0];
                    vin_next   = s_tdata[IN_W-1:TIME_W];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (hit) begin
                    res_slope_next  = last_slope_reg;
                    res_valid_next  = last_valid_reg;
                    res_reused_next = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    wr_en           = 1'b1;
                    wp_next         = wp_inc;
                    fill_next       = fill_inc;
                    res_reused_next = 1'b0;
                    if (n_calc < CNT_W'(2)) begin
                        last_slope_next = '0;
                        last_valid_next = 1'b0;
                        res_slope_next  = '0;
                        res_valid_next  = 1'b0;
                        state_next      = ST_OUT;
                    end else begin
                        n_next     = n_calc;
                        ptr_next   = start_calc;
                        cnt_next   = CNT_W'(1);
                        ph_next    = 1'b0;
                        dt_next    = '0;
                        ds_next    = '0;
                        prod_next  = '0;
                        sdt_next   = '0;
                        sds_next   = '0;
                        sdtds_next = '0;
                        sdt2_next  = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                ptr_next   = ptr_inc(ptr_reg);
                state_next = ST_BASE;
            end
            ST_BASE: begin
                t0_next    = rd_data.stamp;
                v0_next    = rd_data.value;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                prod_next = prod_w;
                if (!ph_reg) begin
                    sdtds_next = sdtds_reg + SDTDS_W'(prod_reg);
                    if (cnt_reg != n_reg) begin
                        dt_next  = dt_new;
                        ds_next  = ds_new;
                        sdt_next = sdt_reg + SDT_W'(dt_new);
                        sds_next = sds_reg + SDS_W'(ds_new);
                        ptr_next = ptr_inc(ptr_reg);
                    end
                    ph_next = 1'b1;
                end else begin
                    sdt2_next = sdt2_reg + SDT2_W'(prod_reg[2*TIME_W-1:0]);
                    ph_next   = 1'b0;
                    if (cnt_reg == n_reg) begin
                        fcnt_next  = '0;
                        state_next = ST_FIN;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FIN: begin
                part_next = part_w;
                fcnt_next = fcnt_reg + 3'd1;
                unique case (fcnt_reg)
                    3'd0: begin
                        num_next = np1;
                        den_next = $signed(np2);
                    end
                    3'd1: num_next = num_reg - NUM_W'(part_reg);
                    3'd2: num_next = num_reg - (NUM_W'(part_reg) <<< CHUNK_W);
                    3'd3: den_next = den_reg - DEN_W'(part_reg);
                    default: begin
                        den_next   = den_reg - (DEN_W'(part_reg) <<< CHUNK_W);
                        state_next = ST_PREP;
                    end
                endcase
                if (fcnt_reg > FIN_LAST) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                neg_next = num_reg[NUM_W-1];
                if (den_reg == '0) begin
                    last_slope_next = '0;
                    last_valid_next = 1'b0;
                    res_slope_next  = '0;
                    res_valid_next  = 1'b0;
                    state_next      = ST_OUT;
                end else if (ovf) begin
                    last_slope_next = num_reg[NUM_W-1] ? OUT_W'(NEG_LIM) : OUT_W'(POS_LIM);
                    last_valid_next = 1'b1;
                    res_slope_next  = num_reg[NUM_W-1] ? OUT_W'(NEG_LIM) : OUT_W'(POS_LIM);
                    res_valid_next  = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    last_slope_next = slope_div;
                    last_valid_next = 1'b1;
                    res_slope_next  = slope_div;
                    res_valid_next  = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_slope_next  = res_slope_reg;
                    out_valid_next  = res_valid_reg;
                    out_reused_next = res_reused_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            fill_reg       <= '0;
            wlen_reg       <= CFG_W'(WLEN_RESET);
            last_slope_reg <= '0;
            last_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            wlen_reg       <= wlen_next;
            last_slope_reg <= last_slope_next;
            last_valid_reg <= last_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tin_reg        <= tin_next;
        vin_reg        <= vin_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        ptr_reg        <= ptr_next;
        ph_reg         <= ph_next;
        t0_reg         <= t0_next;
        v0_reg         <= v0_next;
        dt_reg         <= dt_next;
        ds_reg         <= ds_next;
        prod_reg       <= prod_next;
        sdt_reg        <= sdt_next;
        sds_reg        <= sds_next;
        sdtds_reg      <= sdtds_next;
        sdt2_reg       <= sdt2_next;
        fcnt_reg       <= fcnt_next;
        part_reg       <= part_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        res_slope_reg  <= res_slope_next;
        res_valid_reg  <= res_valid_next;
        res_reused_reg <= res_reused_next;
        out_slope_reg  <= out_slope_next;
        out_valid_reg  <= out_valid_next;
        out_reused_reg <= out_reused_next;
    end

endmodule
